[hdl/rse_pkg.sv]
// ============================================================================
// rse_pkg - shared types, constants and helpers for the Rabbit encryptor
// Holds the round constants, the sequencer state codes, the control bundle
// passed from the sequencer to the round datapath and small bit helpers.
// ============================================================================
package rse_pkg;

  // Eight 32-bit words: state, counters or g-function results.
  typedef logic [7:0][31:0] word8_t;

  // Counter increments, one per counter word.
  localparam word8_t RoundConst = {
    32'hD34D34D3, 32'h4D34D34D, 32'h34D34D34, 32'hD34D34D3,
    32'h4D34D34D, 32'h34D34D34, 32'hD34D34D3, 32'h4D34D34D
  };

  // Step numbers within a round for each stage; the state mix is the last step.
  localparam logic [3:0] CntLastCtr = 4'd7;
  localparam logic [3:0] CntFirstU  = 4'd1;
  localparam logic [3:0] CntLastU   = 4'd8;
  localparam logic [3:0] CntFirstSq = 4'd2;
  localparam logic [3:0] CntLastSq  = 4'd9;
  localparam logic [3:0] CntFirstG  = 4'd3;
  localparam logic [3:0] CntLastG   = 4'd10;
  localparam logic [3:0] CntMix     = 4'd11;

  // Rounds in each setup phase, minus one.
  localparam logic [1:0] SetupRoundsLast = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CfgKeyLow  = 2'd0;
  localparam logic [1:0] CfgKeyHigh = 2'd1;
  localparam logic [1:0] CfgIv      = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_IVMIX,
    ST_EMIT
  } state_t;

  // Which group of rounds is running.
  typedef enum logic [1:0] {
    SEG_KEY,
    SEG_IV,
    SEG_WORK
  } seg_t;

  // Control bundle from the sequencer to the round datapath.
  typedef struct packed {
    logic       load;   // load state and counters from the key
    logic       ivmix;  // fold state and IV into the counters
    logic       rnd;    // a round step is active
    logic [3:0] cnt;    // step within the round
  } ctl_t;

  function automatic logic [31:0] rotl16(input logic [31:0] x);
    return {x[15:0], x[31:16]};
  endfunction

  function automatic logic [31:0] rotl8(input logic [31:0] x);
    return {x[23:0], x[31:24]};
  endfunction

  // Sixteen-bit key word at a three-bit index.
  function automatic logic [15:0] key_word(input logic [127:0] key,
                                           input logic [2:0] idx);
    return key[{idx, 4'b0000} +: 16];
  endfunction

endpackage

[hdl/rse_core.sv]
// ============================================================================
// rse_core - Rabbit state, counters and the shared round unit
// Keeps the eight state and counter words. A round is run one word at a
// time: counter add, state plus counter, a single 32x32 squarer and the
// g-function fold, then all state words are mixed in one final step.
// ============================================================================
module rse_core (
  input  logic            clk,
  input  logic            rst_n,
  input  rse_pkg::ctl_t   ctl,
  input  logic [127:0]    key,
  input  logic [63:0]     iv,
  input  logic [1:0]      pos,
  output logic [31:0]     keystream
);
  import rse_pkg::*;

  word8_t      s_r, s_nxt;
  word8_t      c_r, c_nxt;
  word8_t      g_r, g_nxt;
  logic        carry_r, carry_nxt;
  logic [31:0] u_r, u_nxt;
  logic [63:0] sq_r, sq_nxt;

  logic [2:0]  ci;
  logic [3:0]  ui4;
  logic [3:0]  gi4;
  logic [32:0] sum;
  logic [31:0] iv0, iv1, mix_hi, mix_lo;

  // Step indexes of the counter, sum and g-function stages of the round pipeline.
  assign ci  = ctl.cnt[2:0];
  assign ui4 = ctl.cnt - CntFirstU;
  assign gi4 = ctl.cnt - CntFirstG;

  assign sum = {1'b0, c_r[ci]} + {1'b0, RoundConst[ci]} + {32'd0, carry_r};

  assign iv0    = iv[31:0];
  assign iv1    = iv[63:32];
  assign mix_hi = {iv1[31:16], iv0[31:16]};
  assign mix_lo = {iv1[15:0], iv0[15:0]};

  // Next state of the datapath.
  always_comb begin
    s_nxt     = s_r;
    c_nxt     = c_r;
    g_nxt     = g_r;
    carry_nxt = carry_r;
    u_nxt     = u_r;
    sq_nxt    = sq_r;

    if (ctl.load) begin
      carry_nxt = 1'b0;
      for (int k = 0; k < 8; k++) begin
        if ((k % 2) == 1) begin
          s_nxt[k] = {key_word(key, 3'(k + 5)), key_word(key, 3'(k + 4))};
          c_nxt[k] = {key_word(key, 3'(k)), key_word(key, 3'(k + 1))};
        end else begin
          s_nxt[k] = {key_word(key, 3'(k + 1)), key_word(key, 3'(k))};
          c_nxt[k] = {key_word(key, 3'(k + 4)), key_word(key, 3'(k + 5))};
        end
      end
    end

    if (ctl.ivmix) begin
      for (int k = 0; k < 8; k++) begin
        c_nxt[k] = c_r[k] ^ s_r[3'(k + 4)];
      end
      c_nxt[0] = c_nxt[0] ^ iv0;
      c_nxt[2] = c_nxt[2] ^ iv1;
      c_nxt[4] = c_nxt[4] ^ iv0;
      c_nxt[6] = c_nxt[6] ^ iv1;
      c_nxt[1] = c_nxt[1] ^ mix_hi;
      c_nxt[5] = c_nxt[5] ^ mix_hi;
      c_nxt[3] = c_nxt[3] ^ mix_lo;
      c_nxt[7] = c_nxt[7] ^ mix_lo;
    end

    if (ctl.rnd) begin
      // Counter advance with the carry chain, one word a step.
      if (ctl.cnt <= CntLastCtr) begin
        c_nxt[ci] = sum[31:0];
        carry_nxt = sum[32];
      end
      // State plus the freshly advanced counter.
      if (ctl.cnt >= CntFirstU && ctl.cnt <= CntLastU) begin
        u_nxt = s_r[ui4[2:0]] + c_r[ui4[2:0]];
      end
      // The shared squarer.
      if (ctl.cnt >= CntFirstSq && ctl.cnt <= CntLastSq) begin
        sq_nxt = 64'(u_r) * 64'(u_r);
      end
      // Fold the square into the g-function result.
      if (ctl.cnt >= CntFirstG && ctl.cnt <= CntLastG) begin
        g_nxt[gi4[2:0]] = sq_r[31:0] ^ sq_r[63:32];
      end
      // Mix all state words once every g-function is ready.
      if (ctl.cnt == CntMix) begin
        s_nxt[0] = g_r[0] + rotl16(g_r[7]) + rotl16(g_r[6]);
        s_nxt[1] = g_r[1] + rotl8(g_r[0]) + g_r[7];
        s_nxt[2] = g_r[2] + rotl16(g_r[1]) + rotl16(g_r[0]);
        s_nxt[3] = g_r[3] + rotl8(g_r[2]) + g_r[1];
        s_nxt[4] = g_r[4] + rotl16(g_r[3]) + rotl16(g_r[2]);
        s_nxt[5] = g_r[5] + rotl8(g_r[4]) + g_r[3];
        s_nxt[6] = g_r[6] + rotl16(g_r[5]) + rotl16(g_r[4]);
        s_nxt[7] = g_r[7] + rotl8(g_r[6]) + g_r[5];
      end
    end
  end

  // Carry is control state; the words are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r  <= s_nxt;
    c_r  <= c_nxt;
    g_r  <= g_nxt;
    u_r  <= u_nxt;
    sq_r <= sq_nxt;
  end

  // Keystream word picked by the position within the round's output.
  always_comb begin
    case (pos)
      2'd0:    keystream = s_r[0] ^ (s_r[5] >> 16) ^ (s_r[3] << 16);
      2'd1:    keystream = s_r[2] ^ (s_r[7] >> 16) ^ (s_r[5] << 16);
      2'd2:    keystream = s_r[4] ^ (s_r[1] >> 16) ^ (s_r[7] << 16);
      default: keystream = s_r[6] ^ (s_r[3] >> 16) ^ (s_r[1] << 16);
    endcase
  end

endmodule

[hdl/rse_ctrl.sv]
// ============================================================================
// rse_ctrl - sequencer of the Rabbit encryptor
// Accepts a request, runs key and IV setup when needed, runs one round at
// the start of every group of four words and hands over the result.
// ============================================================================
module rse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_restart,
  input  logic           out_free,
  output logic           in_stall,
  output logic           emit,
  output logic [1:0]     pos,
  output rse_pkg::ctl_t  ctl
);
  import rse_pkg::*;

  state_t     state_r, state_nxt;
  seg_t       seg_r, seg_nxt;
  logic [1:0] rcnt_r, rcnt_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       done_r, done_nxt;

  assign pos = pos_r;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seg_r   <= SEG_WORK;
      rcnt_r  <= 2'd0;
      cnt_r   <= 4'd0;
      pos_r   <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      rcnt_r  <= rcnt_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      done_r  <= done_nxt;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    rcnt_nxt  = rcnt_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    done_nxt  = done_r;
    in_stall  = 1'b1;
    emit      = 1'b0;
    ctl       = '0;
    ctl.cnt   = cnt_r;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_restart || !done_r) begin
            state_nxt = ST_LOAD;
          end else if (pos_r == 2'd0) begin
            seg_nxt   = SEG_WORK;
            cnt_nxt   = 4'd0;
            state_nxt = ST_ROUND;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_LOAD: begin
        ctl.load  = 1'b1;
        seg_nxt   = SEG_KEY;
        rcnt_nxt  = 2'd0;
        cnt_nxt   = 4'd0;
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        ctl.rnd = 1'b1;
        if (cnt_r == CntMix) begin
          cnt_nxt = 4'd0;
          case (seg_r)
            SEG_KEY: begin
              if (rcnt_r == SetupRoundsLast) begin
                state_nxt = ST_IVMIX;
              end else begin
                rcnt_nxt = rcnt_r + 2'd1;
              end
            end
            SEG_IV: begin
              // Setup finished; the first word of a group needs a round.
              if (rcnt_r == SetupRoundsLast) begin
                done_nxt = 1'b1;
                pos_nxt  = 2'd0;
                seg_nxt  = SEG_WORK;
              end else begin
                rcnt_nxt = rcnt_r + 2'd1;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end

      ST_IVMIX: begin
        ctl.ivmix = 1'b1;
        seg_nxt   = SEG_IV;
        rcnt_nxt  = 2'd0;
        cnt_nxt   = 4'd0;
        state_nxt = ST_ROUND;
      end

      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          pos_nxt   = pos_r + 2'd1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/rabbit_stream_encrypt.sv]
// A word inside a group of four comes from the current state; the first
// word of a group waits for a round, and a request that runs setup waits
// for key and IV setup and a round. New requests are taken only after the
// last word is emitted; rounds share a counter adder and a 32x32 squarer.
// Reset (synchronous, rst_n low) clears the sequencer and the key and IV
// registers; the first request after reset always runs key and IV setup.
// ============================================================================
// rabbit_stream_encrypt - Rabbit stream cipher encryptor, top level
// Holds the configuration registers and the output register, and joins the
// sequencer to the round datapath.
// ============================================================================
module rabbit_stream_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  input  logic [31:0] in_plaintext_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_ciphertext_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import rse_pkg::*;

  logic [63:0] key_low_r, key_low_nxt;
  logic [63:0] key_high_r, key_high_nxt;
  logic [63:0] iv_r, iv_nxt;
  logic [31:0] pt_r, pt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic        accept;
  logic        out_free;
  logic        emit;
  logic [1:0]  pos;
  logic [31:0] keystream;
  ctl_t        ctl;

  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  // Configuration writes.
  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    iv_nxt       = iv_r;
    if (cfg_we) begin
      case (cfg_index)
        CfgKeyLow:  key_low_nxt  = cfg_wdata;
        CfgKeyHigh: key_high_nxt = cfg_wdata;
        CfgIv:      iv_nxt       = cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Request capture and result register.
  always_comb begin
    pt_nxt        = accept ? in_plaintext_word : pt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (emit) begin
      out_data_nxt  = pt_r ^ keystream;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r   <= 64'd0;
      key_high_r  <= 64'd0;
      iv_r        <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      key_low_r   <= key_low_nxt;
      key_high_r  <= key_high_nxt;
      iv_r        <= iv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r       <= pt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_ciphertext_word = out_data_r;

  rse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .out_free   (out_free),
    .in_stall   (in_stall),
    .emit       (emit),
    .pos        (pos),
    .ctl        (ctl)
  );

  rse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .key       ({key_high_r, key_low_r}),
    .iv        (iv_r),
    .pos       (pos),
    .keystream (keystream)
  );

endmodule
